@@ rtl/core/ohd_pkg.sv @@
// Shared types and constants for the outgoing handshake detector.
// Self-contained; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package ohd_pkg;

   localparam int WORD_LEN = 12;

   localparam logic [7:0] CH_XON   = 8'h11;
   localparam logic [7:0] CH_XOFF  = 8'h13;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_UPC   = 8'h43;
   localparam logic [7:0] CH_LOW   = 8'h20;
   localparam logic [7:0] CH_HIGH  = 8'h7E;

   localparam logic [31:0]           WORD_HDR = "EMSI";
   localparam logic [8*WORD_LEN-1:0] WORD_REQ = {WORD_HDR, "_REQA77E"};
   localparam logic [8*WORD_LEN-1:0] WORD_NAK = {WORD_HDR, "_NAKEEC3"};
   localparam logic [8*WORD_LEN-1:0] WORD_INQ = {WORD_HDR, "_INQC816"};

   typedef enum logic [1:0] {
      FN_BYTE  = 2'd0,
      FN_TICK  = 2'd1,
      FN_LINE  = 2'd2,
      FN_START = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      EV_NONE    = 4'd0,
      EV_RESYNC  = 4'd1,
      EV_EMSI    = 4'd2,
      EV_YOOHOO  = 4'd3,
      EV_FTS1    = 4'd4,
      EV_ECHO    = 4'd5,
      EV_TIMEOUT = 4'd6,
      EV_LINE    = 4'd7,
      EV_UNEXP   = 4'd8
   } event_type;

   typedef enum logic [2:0] {
      CSR_ENABLE      = 3'd0,
      CSR_ENQ_CODE    = 3'd1,
      CSR_TSYNC_CODE  = 3'd2,
      CSR_MASTER_SEC  = 3'd3,
      CSR_FIRST_SYNC  = 3'd4,
      CSR_SYNC_PERIOD = 3'd5,
      CSR_UNEXP_LIMIT = 3'd6
   } csr_index_type;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'd32) : c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/ohd_if.sv @@
// Valid/ready channels of the outgoing handshake detector: request and response.
// No dependencies beyond plain logic types.
`timescale 1ns / 1ps
`default_nettype none

interface ohd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] rx_byte;

   modport source (output valid, func, rx_byte, input ready);
   modport sink   (input valid, func, rx_byte, output ready);
endinterface

interface ohd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] event_res;
   logic       send_inquiry;
   logic       send_yoohoo;
   logic       send_tsync;
   logic       running;

   modport source (output valid, event_res, send_inquiry, send_yoohoo, send_tsync,
                   running, input ready);
   modport sink   (input valid, event_res, send_inquiry, send_yoohoo, send_tsync,
                   running, output ready);
endinterface

`default_nettype wire

@@ rtl/core/outgoing_handshake_detector.sv @@
// Outgoing handshake detector: EMSI / YooHoo / FTS-1 session start detection.
// Depends on ohd_pkg and the channel interfaces in ohd_if.sv.
//
// Usage:
//   req_chan carries one beat per event: a received byte, a one-second tick,
//   a line error or a start command. rsp_chan returns exactly one beat for each
//   request beat, in order: the event code, the resync send flags and whether
//   detection is still running. csr_* writes the seven setup registers; write
//   them only while no request is in flight.
//   A request beat is accepted into the input register and moves on to the
//   output register, where its response beat turns valid.
//   Throughput is one beat per cycle while rsp_chan does not stall; all decode,
//   counting and word compare is combinational logic between those two
//   registers.
//   Reset clears the session (not running), empties both registers and loads
//   the setup registers with their defaults. A start beat is required to arm.
//   When the response side stalls, the output register holds its beat and the
//   input register can still take one more; req_chan.ready drops only when
//   both are full.
`timescale 1ns / 1ps
`default_nettype none

module outgoing_handshake_detector (
   input  wire logic       clock,
   input  wire logic       reset,
   ohd_req_if.sink         req_chan,
   ohd_rsp_if.source       rsp_chan,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_wdata
);
   import ohd_pkg::*;

   // setup registers
   logic [2:0] enable_ff;
   logic [7:0] enq_code_ff, tsync_code_ff, master_sec_ff, first_sync_ff;
   logic [7:0] sync_period_ff, unexp_limit_ff;

   // input register
   logic       in_vld_ff;
   func_type   func_ff;
   logic [7:0] byte_ff;

   // output register
   logic       out_vld_ff;
   event_type  ev_ff;
   logic [2:0] send_ff;
   logic       running_ff;

   // session state
   logic       active_ff, active_in;
   logic [1:0] enq_cnt_ff, enq_cnt_in;
   logic [1:0] sync_cnt_ff, sync_cnt_in;
   logic [3:0] word_pos_ff, word_pos_in;
   logic       in_word_ff, in_word_in;
   logic [7:0] unexp_cnt_ff, unexp_cnt_in;
   logic [7:0] master_ff, master_in;
   logic [7:0] sync_left_ff, sync_left_in;
   logic [7:0] word_chars_ff [WORD_LEN];

   logic       adv;
   event_type  ev_in;
   logic       resync;
   logic       char_we;
   logic [7:0] up_c;
   logic [1:0] enq_thresh, sync_need, enq_inc, sync_inc;
   logic [7:0] unexp_inc;
   logic [8*WORD_LEN-1:0] word_full;
   logic       can_emsi, can_yoohoo, can_fts;

   assign adv            = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || adv;

   assign can_emsi   = enable_ff[0];
   assign can_yoohoo = enable_ff[1];
   assign can_fts    = enable_ff[2];
   assign enq_thresh = can_emsi ? 2'd2 : 2'd1;
   assign sync_need  = (can_emsi || can_yoohoo) ? 2'd2 : 2'd1;
   assign enq_inc    = (enq_cnt_ff == 2'd3) ? 2'd3 : enq_cnt_ff + 2'd1;
   assign sync_inc   = (sync_cnt_ff == 2'd3) ? 2'd3 : sync_cnt_ff + 2'd1;
   assign unexp_inc  = (unexp_cnt_ff == 8'hFF) ? 8'hFF : unexp_cnt_ff + 8'd1;
   assign up_c       = upcase(byte_ff);

   // word as it stands once the current byte closes it
   always_comb begin
      for (int i = 0; i < WORD_LEN; i++) begin
         word_full[8*(WORD_LEN-1-i) +: 8] = (i == WORD_LEN - 1) ? up_c : word_chars_ff[i];
      end
   end

   always_comb begin
      active_in    = active_ff;
      enq_cnt_in   = enq_cnt_ff;
      sync_cnt_in  = sync_cnt_ff;
      word_pos_in  = word_pos_ff;
      in_word_in   = in_word_ff;
      unexp_cnt_in = unexp_cnt_ff;
      master_in    = master_ff;
      sync_left_in = sync_left_ff;
      ev_in        = EV_NONE;
      resync       = 1'b0;
      char_we      = 1'b0;

      if (func_ff == FN_START) begin
         active_in    = 1'b1;
         enq_cnt_in   = 2'd0;
         sync_cnt_in  = 2'd0;
         word_pos_in  = 4'd0;
         in_word_in   = 1'b0;
         unexp_cnt_in = 8'd0;
         master_in    = master_sec_ff;
         sync_left_in = first_sync_ff;
      end else if (active_ff) begin
         unique case (func_ff)
            FN_LINE: begin
               ev_in = EV_LINE;
            end
            FN_TICK: begin
               if (master_ff <= 8'd1) begin
                  master_in = 8'd0;
                  ev_in     = EV_TIMEOUT;
               end else begin
                  master_in = master_ff - 8'd1;
                  if (sync_left_ff <= 8'd1) begin
                     sync_left_in = sync_period_ff;
                     ev_in        = EV_RESYNC;
                     resync       = 1'b1;
                  end else begin
                     sync_left_in = sync_left_ff - 8'd1;
                  end
               end
            end
            FN_BYTE: begin
               priority if (byte_ff == CH_XON || byte_ff == CH_XOFF) begin
                  // drop flow control
               end else if (byte_ff == enq_code_ff) begin
                  enq_cnt_in = enq_inc;
                  if (enq_inc >= enq_thresh && can_yoohoo) ev_in = EV_YOOHOO;
               end else if (byte_ff == tsync_code_ff) begin
                  sync_cnt_in = sync_inc;
                  if (sync_inc > sync_need && can_fts) ev_in = EV_FTS1;
               end else if (can_emsi && byte_ff > CH_LOW && byte_ff < CH_HIGH) begin
                  if (byte_ff != CH_UPC) sync_cnt_in = 2'd0;
                  enq_cnt_in = 2'd0;
                  if (byte_ff == CH_STAR) begin
                     word_pos_in = 4'd0;
                     in_word_in  = 1'b1;
                  end else if (in_word_ff) begin
                     char_we     = 1'b1;
                     word_pos_in = word_pos_ff + 4'd1;
                     if (word_pos_ff == 4'(WORD_LEN - 1)) begin
                        in_word_in = 1'b0;
                        if (word_full == WORD_REQ || word_full == WORD_NAK) begin
                           ev_in = EV_EMSI;
                        end else if (word_full == WORD_INQ) begin
                           sync_left_in = sync_period_ff;
                           ev_in        = EV_ECHO;
                        end else if (word_full[8*WORD_LEN-1 -: 32] == WORD_HDR) begin
                           unexp_cnt_in = unexp_inc;
                           if (unexp_inc > unexp_limit_ff) ev_in = EV_UNEXP;
                        end
                     end
                  end
               end else begin
                  // abort a word in progress
                  in_word_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
         if (ev_in != EV_NONE && ev_in != EV_RESYNC && ev_in != EV_ECHO) active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 3'd7;
         enq_code_ff    <= 8'd5;
         tsync_code_ff  <= 8'd174;
         master_sec_ff  <= 8'd60;
         first_sync_ff  <= 8'd10;
         sync_period_ff <= 8'd5;
         unexp_limit_ff <= 8'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:      enable_ff      <= csr_wdata[2:0];
            CSR_ENQ_CODE:    enq_code_ff    <= csr_wdata;
            CSR_TSYNC_CODE:  tsync_code_ff  <= csr_wdata;
            CSR_MASTER_SEC:  master_sec_ff  <= csr_wdata;
            CSR_FIRST_SYNC:  first_sync_ff  <= csr_wdata;
            CSR_SYNC_PERIOD: sync_period_ff <= csr_wdata;
            CSR_UNEXP_LIMIT: unexp_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         active_ff    <= 1'b0;
         enq_cnt_ff   <= 2'd0;
         sync_cnt_ff  <= 2'd0;
         word_pos_ff  <= 4'd0;
         in_word_ff   <= 1'b0;
         unexp_cnt_ff <= 8'd0;
         master_ff    <= 8'd0;
         sync_left_ff <= 8'd0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            in_vld_ff <= 1'b1;
         end else if (adv) begin
            in_vld_ff <= 1'b0;
         end
         if (adv) begin
            out_vld_ff   <= 1'b1;
            active_ff    <= active_in;
            enq_cnt_ff   <= enq_cnt_in;
            sync_cnt_ff  <= sync_cnt_in;
            word_pos_ff  <= word_pos_in;
            in_word_ff   <= in_word_in;
            unexp_cnt_ff <= unexp_cnt_in;
            master_ff    <= master_in;
            sync_left_ff <= sync_left_in;
         end else if (rsp_chan.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         func_ff <= func_type'(req_chan.func);
         byte_ff <= req_chan.rx_byte;
      end
      if (adv) begin
         ev_ff      <= ev_in;
         send_ff    <= resync ? enable_ff : 3'd0;
         running_ff <= active_in;
      end
      if (adv && char_we) begin
         word_chars_ff[word_pos_ff] <= up_c;
      end
   end

   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.event_res    = ev_ff;
   assign rsp_chan.send_inquiry = send_ff[0];
   assign rsp_chan.send_yoohoo  = send_ff[1];
   assign rsp_chan.send_tsync   = send_ff[2];
   assign rsp_chan.running      = running_ff;

   a_send_only_resync: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && ev_ff != EV_RESYNC |-> send_ff == 3'd0)
      else $error("send flags set on a non-resync beat");

   a_terminal_stops: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && ev_ff != EV_NONE && ev_ff != EV_RESYNC && ev_ff != EV_ECHO
      |-> !running_ff && !active_ff)
      else $error("session still running after success or failure");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      adv && !active_ff && func_ff != FN_START |=> ev_ff == EV_NONE && !running_ff)
      else $error("event raised while not running");

   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      adv && func_ff == FN_START |=> out_vld_ff && running_ff && active_ff)
      else $error("start beat did not arm the session");

endmodule

`default_nettype wire
